### rtl/counting_bloom_filter_core_assert.svh
// assertion macros shared by the checker
`ifndef COUNTING_BLOOM_FILTER_CORE_ASSERT_SVH
`define COUNTING_BLOOM_FILTER_CORE_ASSERT_SVH
// same-cycle implication, disabled in reset
`define CBF_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("counting bloom filter check failed");
// next-cycle implication, disabled in reset
`define CBF_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("counting bloom filter check failed");
`endif

### rtl/cbf_pkg.sv
// ----------------------------------------------------------------------------
// cbf_pkg
// Types, codes and defaults shared by the counting bloom filter modules.
// ----------------------------------------------------------------------------
package cbf_pkg;

    localparam int DEF_CELLS        = 1024;
    localparam int DEF_COUNTER_BITS = 4;
    localparam int DEF_HASHES       = 4;

    localparam int DIGEST_FIELDS = 4;
    localparam int DIGEST_W      = 32;
    localparam int CFG_CELLS_W   = 11;
    localparam int CFG_INDEX_W   = 2;
    localparam int EST_W         = 4;
    localparam int CNT_W         = 3;
    localparam int QUEUE_DEPTH   = 2;

    typedef enum logic [1:0] {
        KIND_ADD    = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_LOOKUP = 2'd2,
        KIND_CLEAR  = 2'd3
    } t_kind;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PARTITIONED      = 2'd0,
        REG_CELLS_IN_USE     = 2'd1,
        REG_MINIMAL_INCREASE = 2'd2
    } t_reg_index;

    typedef struct packed {
        t_kind               kind;
        logic [DIGEST_W-1:0] digest_0;
        logic [DIGEST_W-1:0] digest_1;
        logic [DIGEST_W-1:0] digest_2;
        logic [DIGEST_W-1:0] digest_3;
    } t_in;

    typedef struct packed {
        logic [EST_W-1:0] estimate;
        logic             ok;
    } t_out;

    typedef struct packed {
        logic                   partitioned;
        logic [CFG_CELLS_W-1:0] cells_in_use;
        logic                   minimal_increase;
    } t_cfg;

    typedef enum logic [2:0] {
        F_IDLE,
        F_PART,
        F_LAUNCH,
        F_DIG,
        F_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_READ,
        B_CAPTURE,
        B_WRITE,
        B_DONE
    } t_back_state;

endpackage

### rtl/cbf_fifo.sv
// ----------------------------------------------------------------------------
// cbf_fifo
// Small show-ahead queue between the index front end and the counter engine.
// ----------------------------------------------------------------------------
module cbf_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [PW:0]   r_cnt;
    logic          w_wr;
    logic          w_rd;

    assign o_full  = (r_cnt == (PW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_wr) begin
                r_wptr <= (r_wptr == PW'(DEPTH-1)) ? '0 : r_wptr + 1'b1;
            end
            if (w_rd) begin
                r_rptr <= (r_rptr == PW'(DEPTH-1)) ? '0 : r_rptr + 1'b1;
            end
            case ({w_wr, w_rd})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### rtl/cbf_div.sv
// ----------------------------------------------------------------------------
// cbf_div
// Restoring divider, one quotient bit per cycle, for digest reduction.
// ----------------------------------------------------------------------------
module cbf_div
    import cbf_pkg::*;
#(
    parameter int DW = 11
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [DIGEST_W-1:0] i_dividend,
    input  logic [DW-1:0]       i_divisor,
    output logic                o_done,
    output logic [DW-1:0]       o_rem
);
    localparam int SW = $clog2(DIGEST_W);

    logic [DIGEST_W-1:0] r_quo;
    logic [DW:0]         r_rem;
    logic [DW-1:0]       r_dvs;
    logic [SW-1:0]       r_step;
    logic                r_busy;
    logic                r_done;
    logic [DW:0]         w_shift;
    logic                w_ge;

    assign w_shift = {r_rem[DW-1:0], r_quo[DIGEST_W-1]};
    assign w_ge    = (w_shift >= {1'b0, r_dvs});
    assign o_done  = r_done;
    assign o_rem   = r_rem[DW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
                r_step <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_quo  <= {r_quo[DIGEST_W-2:0], w_ge};
                r_rem  <= w_ge ? (w_shift - {1'b0, r_dvs}) : w_shift;
                r_step <= r_step + 1'b1;
                if (r_step == SW'(DIGEST_W-1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

### rtl/cbf_front.sv
// ----------------------------------------------------------------------------
// cbf_front
// Accepts items, turns digests into distinct cell indices, queues commands.
// ----------------------------------------------------------------------------
module cbf_front
    import cbf_pkg::*;
#(
    parameter int CELLS  = DEF_CELLS,
    parameter int HASHES = DEF_HASHES,
    parameter int QW     = 2 + CNT_W + DIGEST_FIELDS * ((CELLS > 1) ? $clog2(CELLS) : 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  t_in           i_item,
    input  t_cfg          i_cfg,
    output logic          o_busy,
    output logic          o_q_push,
    output logic [QW-1:0] o_q_data,
    input  logic          i_q_full
);
    localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CW = $clog2(CELLS + 1);
    localparam int K  = (HASHES < DIGEST_FIELDS) ? HASHES : DIGEST_FIELDS;
    // reciprocal of K, exact for every cell count below 2**CW
    localparam int PSH    = CW + 2;
    localparam int PRECIP = ((1 << PSH) + K - 1) / K;

    t_front_state        r_state;
    t_front_state        n_state;
    t_kind               r_kind;
    logic [DIGEST_W-1:0] r_dig [DIGEST_FIELDS];
    logic [1:0]          r_i;
    logic [CW-1:0]       r_part;
    logic [AW-1:0]       r_idx [DIGEST_FIELDS];
    logic [CNT_W-1:0]    r_n;

    logic [DIGEST_W-1:0] w_cfg_cells;
    logic [CW-1:0]       w_cells;
    logic [CW+PSH:0]     w_part_prod;
    logic [CW-1:0]       w_part;
    logic                w_div_start;
    logic [DIGEST_W-1:0] w_div_a;
    logic [CW-1:0]       w_div_b;
    logic                w_div_done;
    logic [CW-1:0]       w_rem;
    logic [CW+1:0]       w_xw;
    logic [AW-1:0]       w_x;
    logic                w_dup;
    logic                w_last;

    // clamp the configured cell count into the usable range
    assign w_cfg_cells = DIGEST_W'(i_cfg.cells_in_use);
    always_comb begin
        if (w_cfg_cells < 32'd4) begin
            w_cells = CW'(4);
        end else if (w_cfg_cells > 32'(CELLS)) begin
            w_cells = CW'(CELLS);
        end else begin
            w_cells = CW'(w_cfg_cells);
        end
    end

    // part size = cells / K by reciprocal multiplication
    assign w_part_prod = (CW+PSH+1)'(w_cells) * (CW+PSH+1)'(PRECIP);
    assign w_part      = CW'(w_part_prod >> PSH);

    cbf_div #(.DW(CW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_a),
        .i_divisor  (w_div_b),
        .o_done     (w_div_done),
        .o_rem      (w_rem)
    );

    always_comb begin
        if (i_cfg.partitioned) begin
            w_xw = (CW+2)'(r_i) * (CW+2)'(r_part) + (CW+2)'(w_rem);
        end else begin
            w_xw = (CW+2)'(w_rem);
        end
        if (w_xw >= (CW+2)'(CELLS)) begin
            w_x = AW'(CELLS - 1);
        end else begin
            w_x = AW'(w_xw);
        end
        w_dup = 1'b0;
        for (int j = 0; j < DIGEST_FIELDS; j++) begin
            if ((CNT_W'(j) < r_n) && (r_idx[j] == w_x)) begin
                w_dup = 1'b1;
            end
        end
    end

    assign w_last = (r_i == 2'(K - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (i_accept) begin
                    if (i_item.kind == KIND_CLEAR) begin
                        n_state = F_PUSH;
                    end else if (i_cfg.partitioned) begin
                        n_state = F_PART;
                    end else begin
                        n_state = F_LAUNCH;
                    end
                end
            end
            F_PART:   n_state = F_LAUNCH;
            F_LAUNCH: n_state = F_DIG;
            F_DIG: begin
                if (w_div_done) begin
                    n_state = w_last ? F_PUSH : F_LAUNCH;
                end
            end
            F_PUSH: begin
                if (!i_q_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        w_div_start = 1'b0;
        w_div_a     = r_dig[r_i];
        w_div_b     = i_cfg.partitioned ? r_part : w_cells;
        o_q_push    = 1'b0;
        unique case (r_state)
            F_LAUNCH: w_div_start = 1'b1;
            F_PUSH:   o_q_push    = !i_q_full;
            default: ;
        endcase
    end

    assign o_busy = (r_state != F_IDLE);

    always_comb begin
        o_q_data = '0;
        for (int j = 0; j < DIGEST_FIELDS; j++) begin
            o_q_data[j*AW +: AW] = r_idx[j];
        end
        o_q_data[DIGEST_FIELDS*AW +: CNT_W] = r_n;
        o_q_data[QW-1 -: 2]                 = r_kind;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == F_IDLE) && i_accept) begin
            r_kind   <= i_item.kind;
            r_dig[0] <= i_item.digest_0;
            r_dig[1] <= i_item.digest_1;
            r_dig[2] <= i_item.digest_2;
            r_dig[3] <= i_item.digest_3;
            r_i      <= '0;
            r_n      <= '0;
        end
        if (r_state == F_PART) begin
            r_part <= w_part;
        end
        if ((r_state == F_DIG) && w_div_done) begin
            if (!w_dup) begin
                r_idx[r_n[1:0]] <= w_x;
                r_n             <= r_n + 1'b1;
            end
            r_i <= r_i + 1'b1;
        end
    end

endmodule

### rtl/cbf_back.sv
// ----------------------------------------------------------------------------
// cbf_back
// Counter engine: reads the object's counters, updates them, posts a result.
// ----------------------------------------------------------------------------
module cbf_back
    import cbf_pkg::*;
#(
    parameter int CELLS        = DEF_CELLS,
    parameter int COUNTER_BITS = DEF_COUNTER_BITS,
    parameter int QW           = 2 + CNT_W + DIGEST_FIELDS * ((CELLS > 1) ? $clog2(CELLS) : 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [QW-1:0] i_q_data,
    input  logic          i_q_empty,
    output logic          o_q_pop,
    input  t_cfg          i_cfg,
    output logic          o_init_busy,
    output t_out          o_res,
    output logic          o_empty,
    input  logic          i_pop
);
    localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CB = COUNTER_BITS;
    localparam logic [CB-1:0] CMAX = '1;

    logic [CB-1:0]    r_mem [CELLS];
    logic [CB-1:0]    r_rdata;
    t_back_state      r_state;
    t_back_state      n_state;
    t_kind            r_kind;
    logic [AW-1:0]    r_idx [DIGEST_FIELDS];
    logic [CNT_W-1:0] r_n;
    logic [1:0]       r_j;
    logic [CB-1:0]    r_val [DIGEST_FIELDS];
    logic [CB-1:0]    r_min;
    logic             r_ok;
    logic [AW-1:0]    r_clr_addr;
    logic             r_from_cmd;
    logic             r_out_valid;
    t_out             r_out;

    logic             w_we;
    logic [AW-1:0]    w_addr;
    logic [CB-1:0]    w_wdata;
    logic             w_jlast;
    logic             w_clr_last;
    logic             w_slot_free;
    logic [CB-1:0]    w_c;
    logic             w_bump;
    logic             w_fail;
    t_kind            w_q_kind;

    assign w_q_kind    = t_kind'(i_q_data[QW-1 -: 2]);
    assign w_jlast     = ({1'b0, r_j} == (r_n - 1'b1));
    assign w_clr_last  = (r_clr_addr == AW'(CELLS - 1));
    assign w_slot_free = !r_out_valid || i_pop;
    assign w_c         = r_val[r_j];

    // per-cell update decision in the write phase
    always_comb begin
        w_bump = 1'b0;
        w_fail = 1'b0;
        case (r_kind)
            KIND_ADD: begin
                if (!(i_cfg.minimal_increase && (w_c != r_min))) begin
                    w_fail = (w_c == CMAX);
                    w_bump = !w_fail;
                end
            end
            KIND_REMOVE: begin
                w_fail = (w_c == '0);
                w_bump = !w_fail;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_CLEAR: begin
                if (w_clr_last) begin
                    n_state = r_from_cmd ? B_DONE : B_IDLE;
                end
            end
            B_IDLE: begin
                if (!i_q_empty) begin
                    n_state = (w_q_kind == KIND_CLEAR) ? B_CLEAR : B_READ;
                end
            end
            B_READ: n_state = B_CAPTURE;
            B_CAPTURE: begin
                if (w_jlast) begin
                    n_state = (r_kind == KIND_LOOKUP) ? B_DONE : B_WRITE;
                end else begin
                    n_state = B_READ;
                end
            end
            B_WRITE: begin
                if (w_jlast) begin
                    n_state = B_DONE;
                end
            end
            B_DONE: begin
                if (w_slot_free) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        w_we    = 1'b0;
        w_addr  = r_idx[r_j];
        w_wdata = '0;
        o_q_pop = 1'b0;
        unique case (r_state)
            B_CLEAR: begin
                w_we   = 1'b1;
                w_addr = r_clr_addr;
            end
            B_IDLE:  o_q_pop = !i_q_empty;
            B_WRITE: begin
                w_we    = w_bump;
                w_wdata = (r_kind == KIND_ADD) ? (w_c + 1'b1) : (w_c - 1'b1);
            end
            default: ;
        endcase
    end

    assign o_init_busy = (r_state == B_CLEAR) && !r_from_cmd;
    assign o_empty     = !r_out_valid;
    assign o_res       = r_out;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addr] <= w_wdata;
        end
        r_rdata <= r_mem[w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_clr_addr  <= '0;
            r_from_cmd  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == B_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if ((r_state == B_IDLE) && !i_q_empty) begin
                r_clr_addr <= '0;
                r_from_cmd <= 1'b1;
            end
            if ((r_state == B_DONE) && w_slot_free) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            B_IDLE: begin
                if (!i_q_empty) begin
                    r_kind <= w_q_kind;
                    for (int j = 0; j < DIGEST_FIELDS; j++) begin
                        r_idx[j] <= i_q_data[j*AW +: AW];
                    end
                    r_n   <= i_q_data[DIGEST_FIELDS*AW +: CNT_W];
                    r_j   <= '0;
                    r_min <= CMAX;
                    r_ok  <= 1'b1;
                end
            end
            B_CAPTURE: begin
                r_val[r_j] <= r_rdata;
                if (r_rdata < r_min) begin
                    r_min <= r_rdata;
                end
                r_j <= w_jlast ? '0 : r_j + 1'b1;
            end
            B_WRITE: begin
                if (w_fail) begin
                    r_ok <= 1'b0;
                end
                r_j <= r_j + 1'b1;
            end
            B_DONE: begin
                if (w_slot_free) begin
                    r_out.estimate <= (r_kind == KIND_LOOKUP) ? EST_W'(r_min) : '0;
                    r_out.ok       <= r_ok;
                end
            end
            default: ;
        endcase
    end

endmodule

### rtl/counting_bloom_filter_core.sv
// the front reduces the K digests one at a time on the serial divider, after
//   a part-size step when partitioned, and holds full until it has queued the
//   n distinct cells; the engine reads them, writes them for add/remove and
//   posts a result; index reduction overlaps the previous item's counter work
// reset: counters are zeroed by a sweep of every cell while full stays high;
//   config returns to plain mode, 1024 cells, minimal increase off
// ----------------------------------------------------------------------------
// counting_bloom_filter_core
// Counting bloom filter with saturating counters and queue-style ports.
// ----------------------------------------------------------------------------
module counting_bloom_filter_core
    import cbf_pkg::*;
#(
    parameter int CELLS        = DEF_CELLS,
    parameter int COUNTER_BITS = DEF_COUNTER_BITS,
    parameter int HASHES       = DEF_HASHES
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   push,
    output logic                   full,
    input  t_in                    i_in_item,
    output logic                   empty,
    input  logic                   pop,
    output t_out                   o_out_item,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_CELLS_W-1:0] i_cfg_data
);
    localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int QW = 2 + CNT_W + DIGEST_FIELDS * AW;

    t_cfg          r_cfg;
    logic          w_front_busy;
    logic          w_init_busy;
    logic          w_accept;
    logic          w_q_push;
    logic [QW-1:0] w_q_wdata;
    logic          w_q_full;
    logic          w_q_pop;
    logic [QW-1:0] w_q_rdata;
    logic          w_q_empty;

    assign o_cfg_ready = 1'b1;
    assign full        = w_front_busy || w_init_busy;
    assign w_accept    = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.partitioned      <= 1'b0;
            r_cfg.cells_in_use     <= CFG_CELLS_W'(1024);
            r_cfg.minimal_increase <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_PARTITIONED:      r_cfg.partitioned      <= i_cfg_data[0];
                REG_CELLS_IN_USE:     r_cfg.cells_in_use     <= i_cfg_data;
                REG_MINIMAL_INCREASE: r_cfg.minimal_increase <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    cbf_front #(.CELLS(CELLS), .HASHES(HASHES), .QW(QW)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_item   (i_in_item),
        .i_cfg    (r_cfg),
        .o_busy   (w_front_busy),
        .o_q_push (w_q_push),
        .o_q_data (w_q_wdata),
        .i_q_full (w_q_full)
    );

    cbf_fifo #(.W(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_wdata),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_data  (w_q_rdata),
        .o_empty (w_q_empty)
    );

    cbf_back #(.CELLS(CELLS), .COUNTER_BITS(COUNTER_BITS), .QW(QW)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_data    (w_q_rdata),
        .i_q_empty   (w_q_empty),
        .o_q_pop     (w_q_pop),
        .i_cfg       (r_cfg),
        .o_init_busy (w_init_busy),
        .o_res       (o_out_item),
        .o_empty     (empty),
        .i_pop       (pop)
    );

endmodule

### rtl/cbf_checker.sv
// ----------------------------------------------------------------------------
// cbf_checker
// Port-level checks: no result beyond accepted items; held results stay put.
// ----------------------------------------------------------------------------
`include "counting_bloom_filter_core_assert.svh"

module cbf_checker
    import cbf_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   push,
    input logic                   full,
    input t_in                    i_in_item,
    input logic                   empty,
    input logic                   pop,
    input t_out                   o_out_item,
    input logic                   i_cfg_valid,
    input logic                   o_cfg_ready,
    input logic [CFG_INDEX_W-1:0] i_cfg_index,
    input logic [CFG_CELLS_W-1:0] i_cfg_data
);
    // items in flight: front, queue, engine and result slot
    localparam int MAX_OPEN = QUEUE_DEPTH + 3;

    logic [3:0] r_open;
    logic       w_in_beat;
    logic       w_out_beat;

    assign w_in_beat  = push && !full;
    assign w_out_beat = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= '0;
        end else begin
            case ({w_in_beat, w_out_beat})
                2'b10:   r_open <= r_open + 1'b1;
                2'b01:   r_open <= r_open - 1'b1;
                default: r_open <= r_open;
            endcase
        end
    end

    `CBF_ASSERT_SAME(a_no_extra_result, w_out_beat, r_open != 4'd0)
    `CBF_ASSERT_SAME(a_open_bounded, 1'b1, r_open <= 4'(MAX_OPEN))
    `CBF_ASSERT_NEXT(a_result_held, !empty && !pop, !empty)
    `CBF_ASSERT_NEXT(a_result_stable, !empty && !pop, $stable(o_out_item))

endmodule

bind counting_bloom_filter_core cbf_checker u_cbf_checker (.*);

### sim/testbench.sv
// ----------------------------------------------------------------------------
// counting bloom filter core testbench
// Drives add, remove, lookup and clear items through the queue ports, keeps
// its own copy of the counter store and settings, and checks every result.
// ----------------------------------------------------------------------------
module testbench;
    import cbf_pkg::*;

    localparam int NCELLS  = 1024;
    localparam int CMAX    = 15;
    localparam int NHASH   = 4;

    logic       i_clk;
    logic       i_rst_n;
    logic       push;
    logic       full;
    t_in        i_in_item;
    logic       empty;
    logic       pop;
    t_out       o_out_item;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_CELLS_W-1:0] i_cfg_data;

    counting_bloom_filter_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_in_item(i_in_item), .empty(empty), .pop(pop), .o_out_item(o_out_item),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // predictor state
    logic [3:0]  store_model [NCELLS];
    logic        part_mode;
    int unsigned cells_reg;
    logic        min_inc;

    t_in  pending_items[$];
    t_out expected_results[$];
    int   mismatches;
    int   push_idle_pct;
    int   pop_idle_pct;
    logic hold_rx;
    logic cfg_busy;

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        mismatches++;
    endtask

    function automatic t_out filter_step(input t_in it);
        t_out r;
        int unsigned cells, part, n, m, c, x;
        int unsigned cell_idx [4];
        logic [31:0] dg [4];
        logic dup;
        r.estimate = '0;
        r.ok = 1'b1;
        if (it.kind == KIND_CLEAR) begin
            foreach (store_model[i]) store_model[i] = '0;
            return r;
        end
        cells = cells_reg;
        if (cells < 4) cells = 4;
        if (cells > NCELLS) cells = NCELLS;
        part = cells / NHASH;
        if (part == 0) part = 1;
        dg[0] = it.digest_0; dg[1] = it.digest_1;
        dg[2] = it.digest_2; dg[3] = it.digest_3;
        n = 0;
        for (int i = 0; i < NHASH; i++) begin
            x = part_mode ? i * part + dg[i] % part : dg[i] % cells;
            if (x >= NCELLS) x = NCELLS - 1;
            dup = 1'b0;
            for (int j = 0; j < n; j++) if (cell_idx[j] == x) dup = 1'b1;
            if (!dup) begin
                cell_idx[n] = x;
                n++;
            end
        end
        m = CMAX;
        for (int i = 0; i < n; i++)
            if (store_model[cell_idx[i]] < m) m = store_model[cell_idx[i]];
        if (it.kind == KIND_LOOKUP) begin
            r.estimate = m[3:0];
            return r;
        end
        for (int i = 0; i < n; i++) begin
            c = store_model[cell_idx[i]];
            if (it.kind == KIND_ADD) begin
                if (!(min_inc && c != m)) begin
                    if (c >= CMAX) r.ok = 1'b0;
                    else store_model[cell_idx[i]] = 4'(c + 1);
                end
            end else begin
                if (c == 0) r.ok = 1'b0;
                else store_model[cell_idx[i]] = 4'(c - 1);
            end
        end
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                expected_results = {expected_results, filter_step(i_in_item)};
                void'(pending_items.pop_front());
            end
            if (!(push && !full) && push) begin
                // keep offering the same beat
            end else if (pending_items.size() > 0 && !cfg_busy &&
                         $urandom_range(99) >= push_idle_pct) begin
                push <= 1'b1;
                i_in_item <= pending_items[0];
            end else begin
                push <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_results.size() == 0) begin
                    report("unexpected result", o_out_item.estimate, -1);
                end else begin
                    if (o_out_item.estimate !== expected_results[0].estimate)
                        report("estimate", o_out_item.estimate,
                               expected_results[0].estimate);
                    if (o_out_item.ok !== expected_results[0].ok)
                        report("ok", o_out_item.ok, expected_results[0].ok);
                    void'(expected_results.pop_front());
                end
            end
            if (hold_rx) begin
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= pop_idle_pct);
            end
        end
    end

    task automatic wait_drained();
        while (pending_items.size() > 0 || push || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_index idx, input int val);
        wait_drained();
        cfg_busy = 1'b1;
        // margin after the last result before touching settings
        repeat (NCELLS + 200) @(posedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data <= val[CFG_CELLS_W-1:0];
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_PARTITIONED:      part_mode = val[0];
            REG_CELLS_IN_USE:     cells_reg = val & 11'h7ff;
            REG_MINIMAL_INCREASE: min_inc = val[0];
            default: ;
        endcase
        cfg_busy = 1'b0;
    endtask

    function automatic t_in make_item(input t_kind k, input int unsigned span);
        t_in it;
        it.kind = k;
        it.digest_0 = (span == 0) ? $urandom : $urandom_range(span);
        it.digest_1 = (span == 0) ? $urandom : $urandom_range(span);
        it.digest_2 = (span == 0) ? $urandom : $urandom_range(span);
        it.digest_3 = (span == 0) ? $urandom : $urandom_range(span);
        return it;
    endfunction

    // random item mix, small digest spans keep counters busy
    task automatic random_items(input int count);
        t_in it;
        int sel;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(99);
            it = make_item(sel < 45 ? KIND_ADD : sel < 70 ? KIND_REMOVE :
                           sel < 98 ? KIND_LOOKUP : KIND_CLEAR,
                           $urandom_range(3) == 0 ? 0 : $urandom_range(1, 40));
            pending_items = {pending_items, it};
        end
    endtask

    initial begin
        t_in it;
        i_rst_n = 1'b0;
        i_in_item = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        cfg_busy = 1'b0;
        mismatches = 0;
        hold_rx = 1'b0;
        push_idle_pct = 26;
        pop_idle_pct = 83;
        foreach (store_model[i]) store_model[i] = '0;
        part_mode = 1'b0;
        cells_reg = 1024;
        min_inc = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, saturation, floor, every kind
        it = '{KIND_ADD, 32'hffffffff, 32'h0, 32'hffffffff, 32'h0};
        repeat (16) pending_items = {pending_items, it};
        it.kind = KIND_LOOKUP; pending_items = {pending_items, it};
        it.kind = KIND_REMOVE; repeat (2) pending_items = {pending_items, it};
        it = '{KIND_REMOVE, 32'h5, 32'h5, 32'h5, 32'h5};
        pending_items = {pending_items, it};
        it = '{KIND_LOOKUP, 32'haaaaaaaa, 32'h55555555, 32'h1, 32'h2};
        pending_items = {pending_items, it};
        it.kind = KIND_CLEAR; pending_items = {pending_items, it};
        it = '{KIND_LOOKUP, 32'hffffffff, 32'h0, 32'hffffffff, 32'h0};
        pending_items = {pending_items, it};
        random_items(300);

        // receiver stalls long past the init sweep so the input backs up
        @(posedge i_clk);
        fork
            begin
                hold_rx = 1'b1;
                repeat (3000) @(posedge i_clk);
                hold_rx = 1'b0;
            end
        join_none
        wait_drained();

        push_idle_pct = 83;
        pop_idle_pct = 26;
        write_reg(REG_MINIMAL_INCREASE, 1);
        write_reg(REG_CELLS_IN_USE, 4);
        random_items(250);
        write_reg(REG_PARTITIONED, 1);
        random_items(250);
        write_reg(REG_CELLS_IN_USE, 1023);
        write_reg(REG_MINIMAL_INCREASE, 0);
        random_items(250);

        push_idle_pct = 0;
        pop_idle_pct = 0;
        write_reg(REG_CELLS_IN_USE, 2047);
        random_items(200);
        write_reg(REG_PARTITIONED, 0);
        write_reg(REG_CELLS_IN_USE, 0);
        random_items(150);
        write_reg(REG_CELLS_IN_USE, 1024);
        random_items(150);
        wait_drained();

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #200000000;
        $display("tb: failure");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/cbf_pkg.sv
rtl/cbf_fifo.sv
rtl/cbf_div.sv
rtl/cbf_front.sv
rtl/cbf_back.sv
rtl/counting_bloom_filter_core.sv
rtl/cbf_checker.sv
sim/testbench.sv
